// ----- src/smie_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smie_pkg: shared types and constants of the stack machine executor
// Opcodes, status codes, write kinds and the controller/datapath link.
// ----------------------------------------------------------------------------
package smie_pkg;

   localparam int DataW = 32;

   localparam logic [7:0] OP_HALT  = 8'd0;
   localparam logic [7:0] OP_PUSHC = 8'd1;
   localparam logic [7:0] OP_ADD   = 8'd2;
   localparam logic [7:0] OP_SUB   = 8'd3;
   localparam logic [7:0] OP_MUL   = 8'd4;
   localparam logic [7:0] OP_DIV   = 8'd5;
   localparam logic [7:0] OP_MOD   = 8'd6;
   localparam logic [7:0] OP_RDINT = 8'd7;
   localparam logic [7:0] OP_WRINT = 8'd8;
   localparam logic [7:0] OP_RDCHR = 8'd9;
   localparam logic [7:0] OP_WRCHR = 8'd10;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_DIVZERO = 3'd1;
   localparam logic [2:0] ST_UNDER   = 3'd2;
   localparam logic [2:0] ST_OVER    = 3'd3;
   localparam logic [2:0] ST_HALTED  = 3'd4;
   localparam logic [2:0] ST_UNKNOWN = 3'd5;

   localparam logic [1:0] WK_NONE = 2'd0;
   localparam logic [1:0] WK_INT  = 2'd1;
   localparam logic [1:0] WK_CHR  = 2'd2;

   typedef struct packed {
      logic load;
      logic div_start;
      logic commit;
   } smie_cmd_type;

   typedef struct packed {
      logic need_div;
      logic div_done;
      logic slot_free;
   } smie_stat_type;

endpackage

// ----- src/smie_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smie_div: iterative signed divider
// Restoring division, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module smie_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      is_mod,
   input  logic [smie_pkg::DataW-1:0] dividend,
   input  logic [smie_pkg::DataW-1:0] divisor,
   output logic                      done,
   output logic [smie_pkg::DataW-1:0] result
);
   import smie_pkg::*;

   localparam int CntW = $clog2(DataW + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CntW-1:0]  cnt_ff;
   logic [DataW-1:0] rem_ff;
   logic [DataW-1:0] quo_ff;
   logic [DataW-1:0] dvs_ff;
   logic             neg_q_ff;
   logic             neg_r_ff;
   logic             is_mod_ff;

   logic [DataW:0]   shifted;
   logic [DataW:0]   trial;
   logic [DataW-1:0] rem_in;
   logic [DataW-1:0] quo_in;
   logic [DataW-1:0] mag_a;
   logic [DataW-1:0] mag_b;

   assign mag_a   = dividend[DataW-1] ? (~dividend + 1'b1) : dividend;
   assign mag_b   = divisor[DataW-1] ? (~divisor + 1'b1) : divisor;
   assign shifted = {rem_ff, quo_ff[DataW-1]};
   assign trial   = shifted - {1'b0, dvs_ff};

   always_comb begin
      if (trial[DataW]) begin
         rem_in = shifted[DataW-1:0];
         quo_in = {quo_ff[DataW-2:0], 1'b0};
      end else begin
         rem_in = trial[DataW-1:0];
         quo_in = {quo_ff[DataW-2:0], 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= CntW'(DataW);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff    <= '0;
         quo_ff    <= mag_a;
         dvs_ff    <= mag_b;
         neg_q_ff  <= dividend[DataW-1] ^ divisor[DataW-1];
         neg_r_ff  <= dividend[DataW-1];
         is_mod_ff <= is_mod;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   always_comb begin
      if (is_mod_ff) begin
         result = neg_r_ff ? (~rem_ff + 1'b1) : rem_ff;
      end else begin
         result = neg_q_ff ? (~quo_ff + 1'b1) : quo_ff;
      end
   end

   assign done = done_ff;

endmodule

// ----- src/smie_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smie_dpath: stack machine datapath
// Operand stack memory, depth count, halt flag, ALU and response register.
// ----------------------------------------------------------------------------
module smie_dpath #(
   parameter int STACK_DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  smie_pkg::smie_cmd_type     cmd,
   output smie_pkg::smie_stat_type    stat,
   input  logic [7:0]                 req_type,
   input  logic [23:0]                req_immediate,
   input  logic signed [31:0]         req_read_value,
   input  logic [7:0]                 req_read_char,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [1:0]                 rsp_write_kind,
   output logic signed [31:0]         rsp_write_value,
   output logic [2:0]                 rsp_status,
   output logic                       rsp_halted
);
   import smie_pkg::*;

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);

   logic [DataW-1:0] stack_ff [STACK_DEPTH];
   logic [DataW-1:0] top_rd_ff;
   logic [DataW-1:0] sec_rd_ff;
   logic [CW-1:0]    count_ff;
   logic [CW-1:0]    count_in;
   logic             halt_flag_ff;
   logic             halt_flag_in;

   logic [7:0]       op_ff;
   logic [23:0]      imm_ff;
   logic [31:0]      rval_ff;
   logic [7:0]       rchr_ff;

   logic             rsp_valid_ff;
   logic [1:0]       kind_ff;
   logic [DataW-1:0] wval_ff;
   logic [2:0]       status_ff;
   logic             halted_ff;

   logic [CW-1:0]    cnt_m1;
   logic [CW-1:0]    cnt_m2;
   logic [AW-1:0]    top_addr;
   logic [AW-1:0]    sec_addr;
   logic [AW-1:0]    wr_addr;
   logic [DataW-1:0] wr_data;
   logic             wr_en;

   logic             is_push;
   logic             is_bin;
   logic             is_wr;
   logic             is_divop;
   logic [2:0]       status_in;
   logic [1:0]       kind_in;
   logic [DataW-1:0] wval_in;
   logic [DataW-1:0] push_val;
   logic [DataW-1:0] alu_res;
   logic [DataW-1:0] div_res;
   logic             div_done;

   assign cnt_m1   = count_ff - CW'(1);
   assign cnt_m2   = count_ff - CW'(2);
   assign top_addr = cnt_m1[AW-1:0];
   assign sec_addr = cnt_m2[AW-1:0];

   assign is_push  = (op_ff == OP_PUSHC) || (op_ff == OP_RDINT) || (op_ff == OP_RDCHR);
   assign is_divop = (op_ff == OP_DIV) || (op_ff == OP_MOD);
   assign is_bin   = (op_ff == OP_ADD) || (op_ff == OP_SUB) || (op_ff == OP_MUL) || is_divop;
   assign is_wr    = (op_ff == OP_WRINT) || (op_ff == OP_WRCHR);

   always_comb begin
      if (op_ff == OP_PUSHC) begin
         push_val = {{8{imm_ff[23]}}, imm_ff};
      end else if (op_ff == OP_RDINT) begin
         push_val = rval_ff;
      end else begin
         push_val = {{24{rchr_ff[7]}}, rchr_ff};
      end
   end

   always_comb begin
      case (op_ff)
         OP_ADD:  alu_res = sec_rd_ff + top_rd_ff;
         OP_SUB:  alu_res = sec_rd_ff - top_rd_ff;
         OP_MUL:  alu_res = sec_rd_ff * top_rd_ff;
         default: alu_res = div_res;
      endcase
   end

   always_comb begin
      status_in    = ST_OK;
      kind_in      = WK_NONE;
      wval_in      = '0;
      halt_flag_in = halt_flag_ff;
      count_in     = count_ff;
      wr_en        = 1'b0;
      wr_addr      = count_ff[AW-1:0];
      wr_data      = push_val;
      if (halt_flag_ff) begin
         status_in = ST_HALTED;
      end else if (op_ff == OP_HALT) begin
         halt_flag_in = 1'b1;
      end else if (is_push) begin
         if (count_ff == CW'(STACK_DEPTH)) begin
            status_in = ST_OVER;
         end else begin
            wr_en    = 1'b1;
            count_in = count_ff + CW'(1);
         end
      end else if (is_bin) begin
         if (count_ff < CW'(2)) begin
            status_in = ST_UNDER;
         end else if (is_divop && (top_rd_ff == '0)) begin
            status_in = ST_DIVZERO;
            count_in  = cnt_m2;
         end else begin
            wr_en    = 1'b1;
            wr_addr  = sec_addr;
            wr_data  = alu_res;
            count_in = cnt_m1;
         end
      end else if (is_wr) begin
         if (count_ff == '0) begin
            status_in = ST_UNDER;
         end else begin
            count_in = cnt_m1;
            wval_in  = top_rd_ff;
            kind_in  = (op_ff == OP_WRINT) ? WK_INT : WK_CHR;
         end
      end else begin
         status_in = ST_UNKNOWN;
      end
   end

   smie_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .is_mod   (op_ff == OP_MOD),
      .dividend (sec_rd_ff),
      .divisor  (top_rd_ff),
      .done     (div_done),
      .result   (div_res)
   );

   always_ff @(posedge clock) begin
      if (cmd.commit && wr_en) begin
         stack_ff[wr_addr] <= wr_data;
      end
      top_rd_ff <= stack_ff[top_addr];
      sec_rd_ff <= stack_ff[sec_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_type;
         imm_ff  <= req_immediate;
         rval_ff <= req_read_value;
         rchr_ff <= req_read_char;
      end
      if (cmd.commit) begin
         kind_ff   <= kind_in;
         wval_ff   <= wval_in;
         status_ff <= status_in;
         halted_ff <= halt_flag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         halt_flag_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            count_ff     <= count_in;
            halt_flag_ff <= halt_flag_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign stat.need_div  = is_bin && is_divop && (status_in == ST_OK);
   assign stat.div_done  = div_done;
   assign stat.slot_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_write_kind  = kind_ff;
   assign rsp_write_value = wval_ff;
   assign rsp_status      = status_ff;
   assign rsp_halted      = halted_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halt_flag_ff |=> halt_flag_ff)
      else $error("halt flag dropped");

   a_halted_frozen: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && halt_flag_ff) |=> $stable(count_ff))
      else $error("stack changed after halt");

endmodule

// ----- src/smie_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smie_ctrl: stack machine controller
// Sequences request load, execute, divider wait and response commit.
// ----------------------------------------------------------------------------
module smie_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  smie_pkg::smie_stat_type stat,
   output smie_pkg::smie_cmd_type  cmd
);
   import smie_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_DIV
   } state_type;

   state_type state_ff;
   logic      ready_ff;

   always_comb begin
      cmd.load      = (state_ff == S_IDLE) && req_valid && ready_ff;
      cmd.div_start = (state_ff == S_EXEC) && stat.need_div;
      cmd.commit    = ((state_ff == S_EXEC) && !stat.need_div && stat.slot_free) ||
                      ((state_ff == S_DIV) && stat.div_done && stat.slot_free);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b1;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid && ready_ff) begin
                  state_ff <= S_EXEC;
                  ready_ff <= 1'b0;
               end
            end
            S_EXEC: begin
               if (stat.need_div) begin
                  state_ff <= S_DIV;
               end else if (stat.slot_free) begin
                  state_ff <= S_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            S_DIV: begin
               if (stat.div_done && stat.slot_free) begin
                  state_ff <= S_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= S_IDLE;
               ready_ff <= 1'b1;
            end
         endcase
      end
   end

   assign req_ready = ready_ff;

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      ready_ff |-> (state_ff == S_IDLE))
      else $error("ready outside idle");

   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.commit && cmd.div_start))
      else $error("commit and divider start together");

   a_load_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == S_EXEC))
      else $error("load not followed by execute");

endmodule

// ----- src/stack_machine_instruction_executor.sv -----
`timescale 1ns / 1ps
// A request is loaded on accept, then executed and committed; the commit sets
// the registered rsp_valid, and only then is the next request accepted. DIV
// and MOD with two operands and a nonzero divisor wait on the divider, which
// yields one quotient bit per cycle. A waiting response with rsp_ready low holds
// the commit and the next accept. Reset clears depth count, halt flag and
// response valid; stack contents are not cleared.
// ----------------------------------------------------------------------------
// stack_machine_instruction_executor: stack machine top level
// One instruction per request on a 32-bit operand stack, one response each.
// ----------------------------------------------------------------------------
module stack_machine_instruction_executor #(
   parameter int STACK_DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_type,
   input  logic [23:0]        req_immediate,
   input  logic signed [31:0] req_read_value,
   input  logic [7:0]         req_read_char,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_write_kind,
   output logic signed [31:0] rsp_write_value,
   output logic [2:0]         rsp_status,
   output logic               rsp_halted
);
   import smie_pkg::*;

   smie_cmd_type  cmd;
   smie_stat_type stat;

   smie_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   smie_dpath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_type        (req_type),
      .req_immediate   (req_immediate),
      .req_read_value  (req_read_value),
      .req_read_char   (req_read_char),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_write_kind  (rsp_write_kind),
      .rsp_write_value (rsp_write_value),
      .rsp_status      (rsp_status),
      .rsp_halted      (rsp_halted)
   );

endmodule
